>>> design/present80_block_encrypt_top_assert.svh
// ----------------------------------------------------------------------------
// PRESENT-80 encryptor assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRESENT80_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define PRESENT80_BLOCK_ENCRYPT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PRS80_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prs80 assertion failed");

// next-cycle implication
`define PRS80_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prs80 assertion failed");

`else

`define PRS80_ASSERT_NOW(lbl, ante, cons)
`define PRS80_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> design/prs80_pkg.sv
// ----------------------------------------------------------------------------
// PRESENT-80 package
// Types, constants and round functions shared by the round cells and top.
// ----------------------------------------------------------------------------
package prs80_pkg;

  localparam int unsigned BLOCK_W  = 64;
  localparam int unsigned KEY_W    = 80;
  localparam int unsigned KEY_LO_W = 64;
  localparam int unsigned KEY_HI_W = 16;
  localparam int unsigned RC_W     = 5;
  localparam int unsigned ROUNDS   = 31;

  // data carried from cell to cell
  typedef struct packed {
    logic [BLOCK_W-1:0] state;
    logic [KEY_W-1:0]   key;
  } stage_t;

  // 4-bit S-box
  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  // round key: top 64 bits of the key register
  function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] k);
    return k[KEY_W-1 -: BLOCK_W];
  endfunction

  // add round key, S-box layer, bit permutation
  function automatic logic [BLOCK_W-1:0] round_fn(input logic [BLOCK_W-1:0] s,
                                                   input logic [KEY_W-1:0]   k);
    logic [BLOCK_W-1:0] x;
    logic [BLOCK_W-1:0] y;
    logic [BLOCK_W-1:0] r;
    x = s ^ round_key(k);
    for (int n = 0; n < BLOCK_W / 4; n++) begin
      y[4*n +: 4] = sbox(x[4*n +: 4]);
    end
    for (int i = 0; i < BLOCK_W; i++) begin
      r[(i / 4) + (i % 4) * (BLOCK_W / 4)] = y[i];
    end
    return r;
  endfunction

  // key schedule: rotate left 61, S-box on top nibble, counter into 19..15
  function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                   input logic [RC_W-1:0]  rc);
    logic [KEY_W-1:0] t;
    t = {k[18:0], k[KEY_W-1:19]};
    t[KEY_W-1 -: 4] = sbox(t[KEY_W-1 -: 4]);
    t[19:15] = t[19:15] ^ rc;
    return t;
  endfunction

endpackage

>>> design/prs80_round_cell.sv
// ----------------------------------------------------------------------------
// PRESENT-80 round cell
// One cipher round and one key schedule step, registered, with local flow
// control so a bubble downstream is filled even when the tail is stalled.
// ----------------------------------------------------------------------------
module prs80_round_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [prs80_pkg::RC_W-1:0]    round_idx,
  input  logic                          up_valid,
  input  prs80_pkg::stage_t             up_data,
  output logic                          up_ready,
  output logic                          dn_valid,
  output prs80_pkg::stage_t             dn_data,
  input  logic                          dn_ready
);

  logic              valid_r;
  logic              valid_nxt;
  prs80_pkg::stage_t data_r;
  prs80_pkg::stage_t data_nxt;

  // cell may take a new request when empty or when its content moves on
  assign up_ready = !valid_r || dn_ready;

  // round datapath
  always_comb begin
    data_nxt.state = prs80_pkg::round_fn(up_data.state, up_data.key);
    data_nxt.key   = prs80_pkg::key_update(up_data.key, round_idx);
    valid_nxt      = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

>>> design/present80_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// PRESENT-80 block encryptor, fully unrolled
// A chain of round cells followed by the final key addition register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one request carries a 64-bit plaintext block and an
//   80-bit key (in_key_high above in_key_low). It is taken at a rising edge
//   with in_valid high and in_stall low.
//   Output channel out_*: one ciphertext block per request, in request order,
//   taken at an edge with out_valid high and out_stall low.
//   Path: an accepted block is registered in each round cell in turn, then in
//   the final key-addition register, which drives out_valid.
//   Throughput: one block per cycle while out_stall stays low; every round has
//   its own cell, so up to ROUNDS + 1 blocks are in flight.
//   Stall: each cell holds its block while the next one is full and stalled;
//   empty cells still fill, so in_stall rises only once the whole chain is
//   full behind a stalled output.
//   Reset (rst_n low, synchronous): all blocks in flight are dropped and the
//   chain comes up empty, ready for a request in the next cycle.
// ----------------------------------------------------------------------------
`include "present80_block_encrypt_top_assert.svh"

module present80_block_encrypt_top #(
  parameter int unsigned ROUNDS = prs80_pkg::ROUNDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [prs80_pkg::BLOCK_W-1:0]   in_plain_block,
  input  logic [prs80_pkg::KEY_LO_W-1:0]  in_key_low,
  input  logic [prs80_pkg::KEY_HI_W-1:0]  in_key_high,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [prs80_pkg::BLOCK_W-1:0]   out_cipher_block
);

  // chain links: link 0 is the input port, link ROUNDS feeds the output reg
  logic              lnk_valid [ROUNDS+1];
  logic              lnk_ready [ROUNDS+1];
  prs80_pkg::stage_t lnk_data  [ROUNDS+1];

  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic                          out_ready;
  logic [prs80_pkg::BLOCK_W-1:0] out_block_r;
  logic [prs80_pkg::BLOCK_W-1:0] out_block_nxt;

  // input port into the chain
  assign lnk_valid[0]       = in_valid;
  assign lnk_data[0].state  = in_plain_block;
  assign lnk_data[0].key    = {in_key_high, in_key_low};
  assign in_stall           = !lnk_ready[0];

  // round cells, counter 1 for the first round
  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    prs80_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_idx (prs80_pkg::RC_W'(g + 1)),
      .up_valid  (lnk_valid[g]),
      .up_data   (lnk_data[g]),
      .up_ready  (lnk_ready[g]),
      .dn_valid  (lnk_valid[g+1]),
      .dn_data   (lnk_data[g+1]),
      .dn_ready  (lnk_ready[g+1])
    );
  end

  // final key addition and output register
  assign out_ready            = !out_valid_r || !out_stall;
  assign lnk_ready[ROUNDS]    = out_ready;

  always_comb begin
    out_block_nxt = lnk_data[ROUNDS].state ^ prs80_pkg::round_key(lnk_data[ROUNDS].key);
    out_valid_nxt = out_ready ? lnk_valid[ROUNDS] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && lnk_valid[ROUNDS]) begin
      out_block_r <= out_block_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cipher_block = out_block_r;

  // checks
  `PRS80_ASSERT_NOW(a_no_stall_when_out_free, !out_stall, !in_stall)
  `PRS80_ASSERT_NXT(a_accept_fills_first_cell, in_valid && !in_stall, lnk_valid[1])
  `PRS80_ASSERT_NOW(a_out_from_last_cell, $rose(out_valid), $past(lnk_valid[ROUNDS]))
  `PRS80_ASSERT_NXT(a_last_cell_holds, lnk_valid[ROUNDS] && !out_ready,
                    lnk_valid[ROUNDS] && $stable(lnk_data[ROUNDS]))

endmodule

>>> tb/present80_block_encrypt_top_tb.sv
// ----------------------------------------------------------------------------
// PRESENT-80 block encryptor testbench
// Sends plaintext/key requests through the valid/stall input channel and
// checks each ciphertext, in order, against a behavioral PRESENT-80 cipher.
// A short directed table (published vectors for the all-zero and all-one
// cases, plus bit-edge patterns) is followed by random requests over several
// sender-idle and receiver-stall mixes, draining the pipeline between mixes.
// ----------------------------------------------------------------------------
module present80_block_encrypt_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLK_W      = prs80_pkg::BLOCK_W;
  localparam int unsigned KLO_W      = prs80_pkg::KEY_LO_W;
  localparam int unsigned KHI_W      = prs80_pkg::KEY_HI_W;
  localparam int unsigned N_ROUNDS   = prs80_pkg::ROUNDS;
  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned PER_MIX    = 390;

  // cipher S-box, nibble in -> nibble out
  localparam logic [3:0] NIB_SUB [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // idle mixes: sender idle percent, receiver stall percent
  localparam int unsigned SEND_PCT [4] = '{0, 52, 0, 6};
  localparam int unsigned RECV_PCT [4] = '{0, 0, 52, 6};

  typedef struct packed {
    logic [BLK_W-1:0] plain;
    logic [KLO_W-1:0] key_lo;
    logic [KHI_W-1:0] key_hi;
    logic [BLK_W-1:0] cipher;
    logic             known;
  } dir_row_t;

  localparam int DIR_N = 13;

  // directed requests; known rows carry published ciphertexts
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 16'h0000,
      64'h5579_C138_7B22_8445, 1'b1},
    '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
      64'hE72C_46C0_F594_5049, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 16'h0000,
      64'hA112_FFC7_2F68_417B, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
      64'h3333_DCD3_2132_10D2, 1'b1},
    '{64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000, 16'h0000, 64'h0, 1'b0},
    '{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000, 16'h0000, 64'h0, 1'b0},
    '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 16'h0000, 64'h0, 1'b0},
    '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 16'h8000, 64'h0, 1'b0},
    '{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 16'h0001, 64'h0, 1'b0},
    '{64'h0123_4567_89AB_CDEF, 64'h0011_2233_4455_6677, 16'h8899, 64'h0, 1'b0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 16'hAAAA, 64'h0, 1'b0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 64'h0, 1'b0},
    '{64'hFEDC_BA98_7654_3210, 64'hFFFF_0000_FFFF_0000, 16'h00FF, 64'h0, 1'b0}
  };

  logic             clk;
  logic             rst_n            = 1'b0;
  logic             in_valid         = 1'b0;
  logic             in_stall;
  logic [BLK_W-1:0] in_plain_block   = '0;
  logic [KLO_W-1:0] in_key_low       = '0;
  logic [KHI_W-1:0] in_key_high      = '0;
  logic             out_valid;
  logic             out_stall        = 1'b0;
  logic [BLK_W-1:0] out_cipher_block;

  logic [BLK_W-1:0] expected_ciphers [$];
  logic [BLK_W-1:0] want_cipher;
  int unsigned      send_idle_pct    = 0;
  int unsigned      recv_stall_pct   = 0;
  int unsigned      mismatch_cnt     = 0;
  int unsigned      quiet_cycles     = 0;

  present80_block_encrypt_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_plain_block   (in_plain_block),
    .in_key_low       (in_key_low),
    .in_key_high      (in_key_high),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cipher_block (out_cipher_block)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // behavioral PRESENT-80: 80-bit key register, round key is its top 64 bits
  function automatic logic [BLK_W-1:0] present80_cipher(input logic [BLK_W-1:0] pt,
                                                         input logic [KLO_W-1:0] klo,
                                                         input logic [KHI_W-1:0] khi);
    logic [BLK_W-1:0] st;
    logic [BLK_W-1:0] sub;
    logic [79:0]      kreg;
    logic [4:0]       rc;
    st   = pt;
    kreg = {khi, klo};
    for (int r = 1; r <= N_ROUNDS; r++) begin
      st = st ^ kreg[79:16];
      for (int n = 0; n < 16; n++) sub[4*n +: 4] = NIB_SUB[st[4*n +: 4]];
      for (int i = 0; i < 64; i++) st[(i / 4) + (i % 4) * 16] = sub[i];
      // key schedule: rotate left 61, S-box top nibble, counter into 19..15
      kreg          = {kreg[18:0], kreg[79:19]};
      kreg[79:76]   = NIB_SUB[kreg[79:76]];
      rc            = 5'(r);
      kreg[19:15]   = kreg[19:15] ^ rc;
    end
    return st ^ kreg[79:16];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // one request: random idle gap, then hold until accepted; starts/ends at negedge
  task automatic send_block(input logic [BLK_W-1:0] pt, input logic [KLO_W-1:0] klo,
                            input logic [KHI_W-1:0] khi, input logic [BLK_W-1:0] ct);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_plain_block <= pt;
    in_key_low     <= klo;
    in_key_high    <= khi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_ciphers.push_back(ct);
    @(negedge clk);
  endtask

  // stop sending until every pending ciphertext has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_ciphers.size() != 0);
  endtask

  // random request, biased a bit toward field extremes and single-bit values
  task automatic rand_block(output logic [BLK_W-1:0] pt, output logic [KLO_W-1:0] klo,
                            output logic [KHI_W-1:0] khi);
    pt  = {$urandom, $urandom};
    klo = {$urandom, $urandom};
    khi = KHI_W'($urandom);
    case ($urandom_range(9))
      0: pt = $urandom_range(1) ? '1 : '0;
      1: {khi, klo} = $urandom_range(1) ? {80{1'b1}} : 80'h0;
      2: pt = 64'h1 << $urandom_range(63);
      3: {khi, klo} = 80'h1 << $urandom_range(79);
      default: ;
    endcase
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // ciphertext checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ciphers.size() == 0) begin
        report_mismatch($sformatf("cipher_block %h with no request pending",
                                  out_cipher_block));
      end else begin
        want_cipher = expected_ciphers.pop_front();
        if (out_cipher_block !== want_cipher)
          report_mismatch($sformatf("cipher_block got %h want %h",
                                    out_cipher_block, want_cipher));
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  initial begin
    while (quiet_cycles < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // main sequence
  initial begin
    logic [BLK_W-1:0] pt;
    logic [KLO_W-1:0] klo;
    logic [KHI_W-1:0] khi;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, back to back
    for (int r = 0; r < DIR_N; r++) begin
      send_block(DIR_TAB[r].plain, DIR_TAB[r].key_lo, DIR_TAB[r].key_hi,
                 DIR_TAB[r].known ? DIR_TAB[r].cipher :
                 present80_cipher(DIR_TAB[r].plain, DIR_TAB[r].key_lo, DIR_TAB[r].key_hi));
    end
    drain_results();

    // random requests under each idle mix
    for (int m = 0; m < 4; m++) begin
      send_idle_pct  = SEND_PCT[m];
      recv_stall_pct = RECV_PCT[m];
      for (int k = 0; k < PER_MIX; k++) begin
        rand_block(pt, klo, khi);
        send_block(pt, klo, khi, present80_cipher(pt, klo, khi));
      end
      drain_results();
    end

    // let any stray output show up
    recv_stall_pct = 0;
    repeat (N_ROUNDS + 9) @(posedge clk);
    if (mismatch_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/prs80_pkg.sv
design/prs80_round_cell.sv
design/present80_block_encrypt_top.sv
tb/present80_block_encrypt_top_tb.sv
